// ----- hdl/pfd_pkg.sv -----
// Shared constants and types for the Playfair pair decryptor.
package pfd_pkg;

   localparam int SIDE  = 5;
   localparam int CELLS = SIDE * SIDE;
   localparam int POS_W = 5;
   localparam int LETTER_W = 8;

   localparam logic [LETTER_W-1:0] LETTER_X = 8'h58;

   // tuser codes on the request channel
   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_DECRYPT = 1'b1;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [CELLS-1:0]    cell_vec_type;
   typedef logic [SIDE-1:0]     line_vec_type;

   typedef struct packed {
      logic       kind;
      logic [POS_W-1:0] key_position;
      letter_type key_letter;
      letter_type cipher_first;
      letter_type cipher_second;
      logic       message_start;
   } req_item_type;

endpackage

// ----- hdl/playfair_pair_decrypt.sv -----
// Playfair digraph decryptor: key square storage, lookup and X replacement.
//
// Usage:
//   The req_ channel carries two kinds of beat, told apart by req_tuser.
//   A load beat writes one letter into one cell (row*5+column) of the 5x5
//   key square; positions 25..31 are dropped. A decrypt beat carries a cipher
//   pair and a message start flag and yields exactly one rsp_ beat; a load
//   beat yields none.
//   Each pair is looked up by content (lowest matching cell wins). Same row
//   shifts left, same column shifts up, otherwise rectangle corners swap.
//   A plaintext X that does not open a message takes the letter before it.
//   A letter missing from the square sets rsp_tuser and passes unchanged.
// Pipeline and throughput:
//   A req_ beat passes one input register, then the lookup logic feeding
//   the result register, before its rsp_ beat. One beat per cycle is
//   sustained while rsp_tready is high; prev_ff loads with the result.
// Reset and stalls:
//   Reset empties both registers and clears the previous letter to zero; the
//   key square is not cleared and must be loaded before use. While rsp_tready
//   is low, the result holds, a waiting decrypt holds in the input register,
//   and load beats still pass through to the square.
module playfair_pair_decrypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] key_position, [12:5] key_letter, [20:13] cipher_first,
   // [28:21] cipher_second, [29] message_start, [31:30] zero
   input  logic [31:0] req_tdata,
   // [0] kind
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] plain_first, [15:8] plain_second
   output logic [15:0] rsp_tdata,
   // [0] not_found
   output logic [0:0]  rsp_tuser
);

   localparam int SIDE  = pfd_pkg::SIDE;
   localparam int CELLS = pfd_pkg::CELLS;

   // input stage
   logic                  a_vld_ff, a_vld_in;
   pfd_pkg::req_item_type a_item_ff, a_item_in;

   // result stage
   logic                rsp_vld_ff, rsp_vld_in;
   pfd_pkg::letter_type plain_first_ff, plain_first_in;
   pfd_pkg::letter_type plain_second_ff, plain_second_in;
   logic                not_found_ff, not_found_in;
   pfd_pkg::letter_type prev_ff, prev_in;

   // key square, no reset: the user must write it before it is read; not enforced here
   pfd_pkg::letter_type key_cells_ff [CELLS];

   logic a_is_load, b_free, a_move, req_take;

   assign a_is_load  = (a_item_ff.kind == pfd_pkg::KIND_LOAD);
   assign b_free     = !rsp_vld_ff || rsp_tready;
   assign a_move     = a_vld_ff && (a_is_load || b_free);
   assign req_tready = !a_vld_ff || a_move;
   assign req_take   = req_tvalid && req_tready;

   // ---------------- content lookup ----------------
   pfd_pkg::cell_vec_type match_a, match_b, hit_a, hit_b, sel_1, sel_2;
   pfd_pkg::line_vec_type row_a, col_a, row_b, col_b;
   pfd_pkg::line_vec_type row_a_up, row_b_up, col_a_left, col_b_left;
   pfd_pkg::line_vec_type row_1, col_1, row_2, col_2;
   pfd_pkg::letter_type   raw_1, raw_2, fix_1, fix_2;
   logic                  missing, same_row, same_col;

   always_comb begin
      for (int i = 0; i < CELLS; i++) begin
         match_a[i] = (key_cells_ff[i] == a_item_ff.cipher_first);
         match_b[i] = (key_cells_ff[i] == a_item_ff.cipher_second);
      end
      // isolate the lowest matching cell
      hit_a = match_a & (~match_a + pfd_pkg::cell_vec_type'(1));
      hit_b = match_b & (~match_b + pfd_pkg::cell_vec_type'(1));
      missing = (match_a == '0) || (match_b == '0);

      row_a = '0; col_a = '0; row_b = '0; col_b = '0;
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE; c++) begin
            row_a[r] = row_a[r] | hit_a[r*SIDE + c];
            col_a[c] = col_a[c] | hit_a[r*SIDE + c];
            row_b[r] = row_b[r] | hit_b[r*SIDE + c];
            col_b[c] = col_b[c] | hit_b[r*SIDE + c];
         end
      end
      same_row = (row_a & row_b) != '0;
      same_col = (col_a & col_b) != '0;

      // one step left / up with wrap: new line j is old line j+1
      for (int j = 0; j < SIDE; j++) begin
         col_a_left[j] = col_a[(j == SIDE-1) ? 0 : j+1];
         col_b_left[j] = col_b[(j == SIDE-1) ? 0 : j+1];
         row_a_up[j]   = row_a[(j == SIDE-1) ? 0 : j+1];
         row_b_up[j]   = row_b[(j == SIDE-1) ? 0 : j+1];
      end

      if (same_row) begin
         row_1 = row_a;    col_1 = col_a_left;
         row_2 = row_b;    col_2 = col_b_left;
      end else if (same_col) begin
         row_1 = row_a_up; col_1 = col_a;
         row_2 = row_b_up; col_2 = col_b;
      end else begin
         row_1 = row_a;    col_1 = col_b;
         row_2 = row_b;    col_2 = col_a;
      end

      raw_1 = '0;
      raw_2 = '0;
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE; c++) begin
            sel_1[r*SIDE + c] = row_1[r] && col_1[c];
            sel_2[r*SIDE + c] = row_2[r] && col_2[c];
            raw_1 = raw_1 | ({pfd_pkg::LETTER_W{sel_1[r*SIDE + c]}} & key_cells_ff[r*SIDE + c]);
            raw_2 = raw_2 | ({pfd_pkg::LETTER_W{sel_2[r*SIDE + c]}} & key_cells_ff[r*SIDE + c]);
         end
      end

      // X takes the letter before it; cascades through the pair
      fix_1 = (raw_1 == pfd_pkg::LETTER_X && !a_item_ff.message_start) ? prev_ff : raw_1;
      fix_2 = (raw_2 == pfd_pkg::LETTER_X) ? fix_1 : raw_2;
   end

   // ---------------- next state ----------------
   always_comb begin
      a_vld_in = a_vld_ff;
      a_item_in = a_item_ff;
      if (a_move) begin
         a_vld_in = 1'b0;
      end
      if (req_take) begin
         a_vld_in = 1'b1;
         a_item_in.kind          = req_tuser[0];
         a_item_in.key_position  = req_tdata[4:0];
         a_item_in.key_letter    = req_tdata[12:5];
         a_item_in.cipher_first  = req_tdata[20:13];
         a_item_in.cipher_second = req_tdata[28:21];
         a_item_in.message_start = req_tdata[29];
      end

      rsp_vld_in      = rsp_vld_ff;
      plain_first_in  = plain_first_ff;
      plain_second_in = plain_second_ff;
      not_found_in    = not_found_ff;
      prev_in         = prev_ff;
      if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (a_move && !a_is_load) begin
         rsp_vld_in   = 1'b1;
         not_found_in = missing;
         if (missing) begin
            plain_first_in  = a_item_ff.cipher_first;
            plain_second_in = a_item_ff.cipher_second;
         end else begin
            plain_first_in  = fix_1;
            plain_second_in = fix_2;
         end
         prev_in = plain_second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
         prev_ff    <= '0;
      end else begin
         a_vld_ff   <= a_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         prev_ff    <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      a_item_ff       <= a_item_in;
      plain_first_ff  <= plain_first_in;
      plain_second_ff <= plain_second_in;
      not_found_ff    <= not_found_in;
   end

   // key load: write one cell, drop positions past the square
   always_ff @(posedge clock) begin
      if (a_move && a_is_load && a_item_ff.key_position < pfd_pkg::POS_W'(CELLS)) begin
         key_cells_ff[a_item_ff.key_position] <= a_item_ff.key_letter;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {plain_second_ff, plain_first_ff};
   assign rsp_tuser  = not_found_ff;

   // ---------------- assertions ----------------
   // a result appears only after a decrypt left the input stage
   a_rsp_from_decrypt: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(a_vld_ff && a_item_ff.kind == pfd_pkg::KIND_DECRYPT))
      else $error("result without a decrypt beat");

   // the previous letter always tracks the shown second letter
   a_prev_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> prev_ff == plain_second_ff)
      else $error("previous letter out of step with result");

   // a decrypt blocked by a full result stage is kept
   a_hold_decrypt: assert property (@(posedge clock) disable iff (reset)
      (a_vld_ff && !a_is_load && rsp_vld_ff && !rsp_tready) |=>
         (a_vld_ff && $stable(a_item_ff)))
      else $error("stalled decrypt lost");

   // back pressure only while the input stage is occupied
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> a_vld_ff)
      else $error("input stalled while empty");

endmodule
